// File: src/assert_macros.svh
// Assertion macros used by the RTL of the IPv4 header checker.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: src/ihc_pkg.sv
// Package for the IPv4 header checker: header offsets, masks, verdict codes.
// No dependencies; imported by every module of the block.
package ihc_pkg;

    // Frame layout
    localparam logic [15:0] HDR_START  = 16'd14;
    localparam int          HDR_WORDS  = 10;
    localparam logic [15:0] HDR_END    = HDR_START + 16'(2 * HDR_WORDS);
    localparam logic [15:0] MIN_FRAME  = 16'd34;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Byte offsets inside the IPv4 header
    localparam logic [4:0] HDR_VERSION = 5'd0;
    localparam logic [4:0] HDR_LEN_HI  = 5'd2;
    localparam logic [4:0] HDR_LEN_LO  = 5'd3;
    localparam logic [4:0] HDR_FLAGS   = 5'd6;
    localparam logic [4:0] HDR_PROTO   = 5'd9;
    localparam logic [2:0] HDR_DST_HI3 = 3'b100;  // offsets 16..19

    // Field masks and values
    localparam logic [7:0]  VERSION_MASK = 8'hF0;
    localparam logic [7:0]  VERSION_V4   = 8'h40;
    localparam logic [7:0]  FLAG_MASK    = 8'hBF;
    localparam logic [7:0]  PROTO_ICMP   = 8'h01;
    localparam logic [7:0]  PROTO_UDP    = 8'h11;
    localparam logic [15:0] SUM_ONES     = 16'hFFFF;

    // Register index (paddr[2])
    localparam logic CFG_IDX_MY_ADDRESS = 1'b0;

    typedef enum logic [3:0] {
        VERDICT_ICMP        = 4'd0,
        VERDICT_UDP         = 4'd1,
        VERDICT_UNKNOWN     = 4'd2,
        VERDICT_UNDERSIZED  = 4'd3,
        VERDICT_BAD_VERSION = 4'd4,
        VERDICT_NOT_MINE    = 4'd5,
        VERDICT_FRAGMENTED  = 4'd6,
        VERDICT_CHECKSUM    = 4'd7,
        VERDICT_LENGTH      = 4'd8
    } verdict_t;

    // Input stage payload
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } byte_beat_t;

    // Result payload
    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] protocol;
    } result_beat_t;

endpackage

// File: src/ihc_if.sv
// Valid/ready channel interfaces of the IPv4 header checker.
// Depends on nothing; used by ihc_frame_check and the top level.
interface ihc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ihc_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] verdict;
    logic [7:0] protocol;

    modport source (output valid, output verdict, output protocol, input ready);
    modport sink   (input valid, input verdict, input protocol, output ready);
endinterface

// File: src/ipv4_header_checker_top.sv
// IPv4 header checker, top level: APB register block and frame datapath.
// Throughput: one frame byte per cycle; a last byte waits only while a verdict beat is held.
// Path: a last byte is captured in the input beat register, then the header logic writes its verdict
// beat into the result register, which raises results.valid.
// Reset: rst_n asynchronous, active low; clears my_address and all per-frame state.
// Depends on ihc_pkg, ihc_if, ihc_apb_regs and ihc_frame_check.
module ipv4_header_checker_top
    import ihc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    ihc_frame_if.sink    frames,
    ihc_result_if.source results
);

    logic [31:0] my_address;

    // Configuration registers
    ihc_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .my_address (my_address)
    );

    // Byte stream datapath
    ihc_frame_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .my_address (my_address),
        .frames     (frames),
        .results    (results)
    );

endmodule

// File: src/ihc_apb_regs.sv
// APB register block of the IPv4 header checker: holds my_address.
// Depends on ihc_pkg.
module ihc_apb_regs
    import ihc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] my_address
);

    logic [31:0] my_address_reg;
    logic [31:0] my_address_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == CFG_IDX_MY_ADDRESS);

    // Register write
    always_comb
    begin
        my_address_next = my_address_reg;
        if (wr_hit)
        begin
            my_address_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_address_reg <= '0;
        end
        else
        begin
            my_address_reg <= my_address_next;
        end
    end

    // Read back; the unused slot reads zero
    assign prdata     = (paddr[2] == CFG_IDX_MY_ADDRESS) ? my_address_reg : 32'd0;
    assign my_address = my_address_reg;

endmodule

// File: src/ihc_frame_check.sv
// Frame datapath: input beat register, per-frame header state, verdict logic
// and result register. Depends on ihc_pkg, ihc_if and assert_macros.svh.
`include "assert_macros.svh"

module ihc_frame_check
    import ihc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   my_address,
    ihc_frame_if.sink     frames,
    ihc_result_if.source  results
);

    // Input stage
    byte_beat_t   s1_reg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic         s1_advance;
    logic         in_accept;

    // Per-frame state
    logic [15:0]  byte_count_reg,      byte_count_next;
    logic [19:0]  sum_accumulator_reg, sum_accumulator_next;
    logic [7:0]   high_byte_hold_reg,  high_byte_hold_next;
    logic         version_ok_reg,      version_ok_next;
    logic         address_match_reg,   address_match_next;
    logic         fragment_seen_reg,   fragment_seen_next;
    logic [15:0]  total_length_reg,    total_length_next;
    logic [7:0]   protocol_hold_reg,   protocol_hold_next;

    // Header state with the current beat applied, before end-of-frame clear
    logic [19:0]  sum_upd;
    logic [7:0]   high_upd;
    logic         version_upd;
    logic         address_upd;
    logic         fragment_upd;
    logic [15:0]  length_upd;
    logic [7:0]   protocol_upd;

    logic         in_hdr;
    logic [15:0]  hdr_off;
    logic [4:0]   hdr_idx;
    logic [7:0]   want_byte;
    logic [15:0]  count_inc;
    logic [16:0]  fold1;
    logic [15:0]  fold2;
    logic         checksum_ok;
    logic         length_ok;
    verdict_t     verdict_calc;
    logic         frame_done;

    // Result register
    result_beat_t out_reg;
    result_beat_t out_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    // Handshake: a non-last beat always moves on, a last beat needs the result slot
    assign s1_advance = s1_valid_reg &&
                        (!s1_reg.last_byte || !out_valid_reg || results.ready);
    assign frames.ready = !s1_valid_reg || s1_advance;
    assign in_accept    = frames.valid && frames.ready;
    assign frame_done   = s1_advance && s1_reg.last_byte;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Header byte position
    assign in_hdr    = (byte_count_reg >= HDR_START) && (byte_count_reg < HDR_END);
    assign hdr_off   = byte_count_reg - HDR_START;
    assign hdr_idx   = hdr_off[4:0];
    assign count_inc = (byte_count_reg == COUNT_MAX) ? COUNT_MAX : byte_count_reg + 16'd1;

    // Destination octet to compare, first octet in the top byte
    always_comb
    begin
        case (hdr_idx[1:0])
            2'd0:    want_byte = my_address[31:24];
            2'd1:    want_byte = my_address[23:16];
            2'd2:    want_byte = my_address[15:8];
            default: want_byte = my_address[7:0];
        endcase
    end

    // Header field capture and checksum accumulate
    always_comb
    begin
        sum_upd      = sum_accumulator_reg;
        high_upd     = high_byte_hold_reg;
        version_upd  = version_ok_reg;
        address_upd  = address_match_reg;
        fragment_upd = fragment_seen_reg;
        length_upd   = total_length_reg;
        protocol_upd = protocol_hold_reg;
        if (in_hdr)
        begin
            if (!hdr_idx[0])
            begin
                high_upd = s1_reg.frame_byte;
            end
            else
            begin
                sum_upd = sum_accumulator_reg +
                          20'({high_byte_hold_reg, s1_reg.frame_byte});
            end
            case (hdr_idx)
                HDR_VERSION: version_upd  = ((s1_reg.frame_byte & VERSION_MASK) == VERSION_V4);
                HDR_LEN_HI:  length_upd   = {s1_reg.frame_byte, total_length_reg[7:0]};
                HDR_LEN_LO:  length_upd   = {total_length_reg[15:8], s1_reg.frame_byte};
                HDR_FLAGS:   fragment_upd = ((s1_reg.frame_byte & FLAG_MASK) != 8'd0);
                HDR_PROTO:   protocol_upd = s1_reg.frame_byte;
                default:     ;
            endcase
            if ((hdr_idx[4:2] == HDR_DST_HI3) && (want_byte != s1_reg.frame_byte))
            begin
                address_upd = 1'b0;
            end
        end
    end

    // End-around carry fold: two passes bring 20 bits into 16
    assign fold1       = {1'b0, sum_upd[15:0]} + 17'(sum_upd[19:16]);
    assign fold2       = fold1[15:0] + 16'(fold1[16]);
    assign checksum_ok = (fold2 == SUM_ONES);
    // count_inc is the saturated frame length on the last beat
    assign length_ok   = (length_upd == (count_inc - HDR_START));

    // Verdict priority
    always_comb
    begin
        if (count_inc < MIN_FRAME)
        begin
            verdict_calc = VERDICT_UNDERSIZED;
        end
        else if (!version_upd)
        begin
            verdict_calc = VERDICT_BAD_VERSION;
        end
        else if (!address_upd)
        begin
            verdict_calc = VERDICT_NOT_MINE;
        end
        else if (fragment_upd)
        begin
            verdict_calc = VERDICT_FRAGMENTED;
        end
        else if (!checksum_ok)
        begin
            verdict_calc = VERDICT_CHECKSUM;
        end
        else if (!length_ok)
        begin
            verdict_calc = VERDICT_LENGTH;
        end
        else if (protocol_upd == PROTO_ICMP)
        begin
            verdict_calc = VERDICT_ICMP;
        end
        else if (protocol_upd == PROTO_UDP)
        begin
            verdict_calc = VERDICT_UDP;
        end
        else
        begin
            verdict_calc = VERDICT_UNKNOWN;
        end
    end

    // State update, cleared after the last beat of a frame
    always_comb
    begin
        byte_count_next      = byte_count_reg;
        sum_accumulator_next = sum_accumulator_reg;
        high_byte_hold_next  = high_byte_hold_reg;
        version_ok_next      = version_ok_reg;
        address_match_next   = address_match_reg;
        fragment_seen_next   = fragment_seen_reg;
        total_length_next    = total_length_reg;
        protocol_hold_next   = protocol_hold_reg;
        if (frame_done)
        begin
            byte_count_next      = '0;
            sum_accumulator_next = '0;
            high_byte_hold_next  = '0;
            version_ok_next      = 1'b0;
            address_match_next   = 1'b1;
            fragment_seen_next   = 1'b0;
            total_length_next    = '0;
            protocol_hold_next   = '0;
        end
        else if (s1_advance)
        begin
            byte_count_next      = count_inc;
            sum_accumulator_next = sum_upd;
            high_byte_hold_next  = high_upd;
            version_ok_next      = version_upd;
            address_match_next   = address_upd;
            fragment_seen_next   = fragment_upd;
            total_length_next    = length_upd;
            protocol_hold_next   = protocol_upd;
        end
    end

    // Result slot
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (frame_done)
        begin
            out_next.verdict  = verdict_calc;
            out_next.protocol = protocol_upd;
            out_valid_next    = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            byte_count_reg      <= '0;
            sum_accumulator_reg <= '0;
            high_byte_hold_reg  <= '0;
            version_ok_reg      <= 1'b0;
            address_match_reg   <= 1'b1;
            fragment_seen_reg   <= 1'b0;
            total_length_reg    <= '0;
            protocol_hold_reg   <= '0;
        end
        else
        begin
            s1_valid_reg        <= s1_valid_next;
            out_valid_reg       <= out_valid_next;
            byte_count_reg      <= byte_count_next;
            sum_accumulator_reg <= sum_accumulator_next;
            high_byte_hold_reg  <= high_byte_hold_next;
            version_ok_reg      <= version_ok_next;
            address_match_reg   <= address_match_next;
            fragment_seen_reg   <= fragment_seen_next;
            total_length_reg    <= total_length_next;
            protocol_hold_reg   <= protocol_hold_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.frame_byte <= frames.frame_byte;
            s1_reg.last_byte  <= frames.last_byte;
        end
        out_reg <= out_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.verdict  = out_reg.verdict;
    assign results.protocol = out_reg.protocol;

    // Checks
    `ASSERT_NEXT(a_done_gives_result, clk, rst_n, frame_done, out_valid_reg)
    `ASSERT_NEXT(a_done_clears_count, clk, rst_n, frame_done, byte_count_reg == 16'd0)
    `ASSERT_NEXT(a_stalled_beat_kept, clk, rst_n, s1_valid_reg && !s1_advance, s1_valid_reg)
    `ASSERT_IMPLY(a_verdict_range, clk, rst_n, out_valid_reg, out_reg.verdict <= VERDICT_LENGTH)

endmodule
